### design/crt_pkg.sv
// Shared types, codes and constants of the collimator ray transmission test.
package crt_pkg;

   localparam int STRIP_COUNT_DEF = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int NUM_W = 64;
   localparam int DEN_W = 32;
   localparam int QUO_W = 36;
   localparam int DIV_LAT = QUO_W + 1;
   localparam int LANES = 6;

   localparam logic [2:0] OUTCOME_DETECTED = 3'd0;
   localparam logic [2:0] OUTCOME_FRONT_BLOCK = 3'd1;
   localparam logic [2:0] OUTCOME_REAR_BLOCK = 3'd2;
   localparam logic [2:0] OUTCOME_MISS = 3'd3;
   localparam logic [2:0] OUTCOME_ZERO_DIR = 3'd4;

   localparam logic [2:0] REG_COSINE = 3'd0;
   localparam logic [2:0] REG_SINE = 3'd1;
   localparam logic [2:0] REG_FRONT_Z = 3'd2;
   localparam logic [2:0] REG_REAR_Z = 3'd3;
   localparam logic [2:0] REG_RADIUS = 3'd4;
   localparam logic [2:0] REG_HALF_WIDTH = 3'd5;
   localparam logic [2:0] REG_STRIP_WIDTH = 3'd6;
   localparam logic [2:0] REG_STRIP_PITCH = 3'd7;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] heading_x;
      logic signed [31:0] heading_y;
      logic signed [31:0] heading_z;
   } req_type;

   typedef struct packed {
      logic [2:0]         outcome;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] value;
   } csr_type;

   typedef struct packed {
      logic signed [15:0] rotation_cosine;
      logic signed [15:0] rotation_sine;
      logic signed [31:0] front_grid_z;
      logic signed [31:0] rear_grid_z;
      logic [30:0]        detector_radius;
      logic [30:0]        grid_half_width;
      logic [30:0]        strip_width;
      logic [30:0]        strip_pitch;
   } cfg_type;

   // plane 0 detector, 1 front grid, 2 rear grid
   typedef struct packed {
      logic               zero_dir;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] heading_x;
      logic signed [31:0] heading_y;
      logic signed [31:0] heading_z;
      logic [2:0][31:0]   dist_mag;
      logic [2:0]         dist_neg;
   } job_type;

   typedef struct packed {
      logic               zero_dir;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic [LANES-1:0]   neg;
   } side_type;

endpackage

### design/crt_ifs.sv
// Valid/ready channel interfaces for request, response and register words.
interface crt_req_if;
   logic             valid;
   logic             ready;
   crt_pkg::req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface crt_rsp_if;
   logic             valid;
   logic             ready;
   crt_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface crt_csr_if;
   logic             valid;
   logic             ready;
   crt_pkg::csr_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

### design/crt_front.sv
// Front end: register file, ray intake, zero-direction check, plane distances.
module crt_front (
   input  logic              clock,
   input  logic              reset,
   crt_req_if.sink           req_chan,
   crt_csr_if.sink           csr_chan,
   output crt_pkg::cfg_type  cfg,
   output crt_pkg::job_type  job,
   output logic              job_valid,
   input  logic              job_ready
);

   crt_pkg::cfg_type cfg_ff;
   crt_pkg::job_type job_ff;
   crt_pkg::job_type job_in;
   logic             job_valid_ff;
   logic [2:0][31:0] plane;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !job_valid_ff || job_ready;
   assign cfg = cfg_ff;
   assign job = job_ff;
   assign job_valid = job_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_cosine <= 16'sd16384;
         cfg_ff.rotation_sine <= 16'sd0;
         cfg_ff.front_grid_z <= 32'sd6554;
         cfg_ff.rear_grid_z <= 32'sd10158080;
         cfg_ff.detector_radius <= 31'd294912;
         cfg_ff.grid_half_width <= 31'd294912;
         cfg_ff.strip_width <= 31'd29491;
         cfg_ff.strip_pitch <= 31'd140083;
      end else if (csr_chan.valid) begin
         case (csr_chan.data.index)
            crt_pkg::REG_COSINE: cfg_ff.rotation_cosine <= csr_chan.data.value[15:0];
            crt_pkg::REG_SINE: cfg_ff.rotation_sine <= csr_chan.data.value[15:0];
            crt_pkg::REG_FRONT_Z: cfg_ff.front_grid_z <= csr_chan.data.value;
            crt_pkg::REG_REAR_Z: cfg_ff.rear_grid_z <= csr_chan.data.value;
            crt_pkg::REG_RADIUS: cfg_ff.detector_radius <= csr_chan.data.value[30:0];
            crt_pkg::REG_HALF_WIDTH: cfg_ff.grid_half_width <= csr_chan.data.value[30:0];
            crt_pkg::REG_STRIP_WIDTH: cfg_ff.strip_width <= csr_chan.data.value[30:0];
            crt_pkg::REG_STRIP_PITCH: cfg_ff.strip_pitch <= csr_chan.data.value[30:0];
            default: begin
            end
         endcase
      end
   end

   assign plane[0] = 32'd0;
   assign plane[1] = cfg_ff.front_grid_z;
   assign plane[2] = cfg_ff.rear_grid_z;

   always_comb begin
      logic signed [32:0] delta;
      job_in.zero_dir = (req_chan.data.heading_z == 32'sd0);
      job_in.start_x = req_chan.data.start_x;
      job_in.start_y = req_chan.data.start_y;
      job_in.heading_x = req_chan.data.heading_x;
      job_in.heading_y = req_chan.data.heading_y;
      job_in.heading_z = req_chan.data.heading_z;
      for (int p = 0; p < 3; p++) begin
         delta = signed'({plane[p][31], plane[p]})
               - signed'({req_chan.data.start_z[31], req_chan.data.start_z});
         job_in.dist_neg[p] = delta[32];
         job_in.dist_mag[p] = delta[32] ? 32'(-delta) : delta[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         job_valid_ff <= 1'b1;
      end else if (job_ready) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         job_ff <= job_in;
      end
   end

endmodule

### design/crt_queue.sv
// Short queue between front end and back end.
module crt_queue (
   input  logic             clock,
   input  logic             reset,
   input  crt_pkg::job_type push_job,
   input  logic             push_valid,
   output logic             push_ready,
   output crt_pkg::job_type pop_job,
   output logic             pop_valid,
   input  logic             pop_take
);

   crt_pkg::job_type                   entry_ff [crt_pkg::QUEUE_DEPTH];
   logic [crt_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [crt_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [crt_pkg::QUEUE_PTR_W:0]      count_ff;
   logic                               push;
   logic                               pop;

   assign push_ready = (count_ff != (crt_pkg::QUEUE_PTR_W + 1)'(crt_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job = entry_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_take && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/crt_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
module crt_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [crt_pkg::NUM_W-1:0]   num,
   input  logic [crt_pkg::DEN_W-1:0]   den,
   output logic [crt_pkg::QUO_W-1:0]   quo,
   output logic                        ovf
);

   localparam int QB = crt_pkg::QUO_W;
   localparam int DW = crt_pkg::DEN_W;
   localparam int HI = crt_pkg::NUM_W - QB;

   logic [DW-1:0] rem_ff [0:QB-1];
   logic [QB-1:0] low_ff [0:QB-1];
   logic [DW-1:0] den_ff [0:QB-1];
   logic [QB-1:0] quo_ff [0:QB];
   logic          ovf_ff [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(num[crt_pkg::NUM_W-1:QB]);
         low_ff[0] <= num[QB-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (DW'(num[crt_pkg::NUM_W-1:QB]) >= den) || (HI > DW);
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_stage
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[j-1], low_ff[j-1][QB-j]};
      assign ge = (trial >= {1'b0, den_ff[j-1]});
      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= quo_ff[j-1] | (ge ? (QB'(1) << (QB - j)) : '0);
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
      if (j < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? DW'(trial - {1'b0, den_ff[j-1]}) : DW'(trial);
               low_ff[j] <= low_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quo = quo_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

### design/crt_back.sv
// Back end: plane crossings, grid rotation and strip tests, detector disc test.
module crt_back #(
   parameter int STRIP_COUNT = crt_pkg::STRIP_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  crt_pkg::cfg_type  cfg,
   input  crt_pkg::job_type  job,
   input  logic              job_valid,
   output logic              job_take,
   crt_rsp_if.source         rsp_chan
);

   localparam int IW = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
   localparam int CMP_W = 50 + IW;
   localparam int L = crt_pkg::LANES;
   localparam int DL = crt_pkg::DIV_LAT;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -37'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic advance;

   // constant bounds from registers
   logic signed [CMP_W-1:0] left_ff  [STRIP_COUNT];
   logic signed [CMP_W-1:0] right_ff [STRIP_COUNT];
   logic signed [CMP_W-1:0] half_ff;
   logic [61:0]             r2_ff;

   // multiply stage
   logic                          a_valid_ff;
   logic [crt_pkg::NUM_W-1:0]     a_num_ff [L];
   logic [crt_pkg::NUM_W-1:0]     a_num_in [L];
   logic [31:0]                   a_den_ff;
   crt_pkg::side_type             a_side_ff;
   crt_pkg::side_type             a_side_in;

   // divider alignment
   logic                          dv_ff   [DL];
   crt_pkg::side_type             side_ff [DL];
   logic [crt_pkg::QUO_W-1:0]     quo [L];
   logic                          ovf [L];

   // crossing stage
   logic                          c_valid_ff;
   logic                          c_zero_ff;
   logic signed [31:0]            c_coord_ff [L];
   logic signed [31:0]            c_coord_in [L];

   // products stage
   logic                          d1_valid_ff;
   logic                          d1_zero_ff;
   logic signed [31:0]            d1_hit_x_ff;
   logic signed [31:0]            d1_hit_y_ff;
   logic signed [47:0]            d1_xc_ff [2];
   logic signed [47:0]            d1_ys_ff [2];
   logic signed [47:0]            d1_yc_ff [2];
   logic signed [47:0]            d1_xs_ff [2];
   logic [63:0]                   d1_sqx_ff;
   logic [63:0]                   d1_sqy_ff;

   // sums stage
   logic                          d2_valid_ff;
   logic                          d2_zero_ff;
   logic signed [31:0]            d2_hit_x_ff;
   logic signed [31:0]            d2_hit_y_ff;
   logic signed [CMP_W-1:0]       d2_xr_ff [2];
   logic signed [CMP_W-1:0]       d2_yr_ff [2];
   logic                          d2_inside_ff;

   // strip stage
   logic                          d3_valid_ff;
   logic                          d3_zero_ff;
   logic signed [31:0]            d3_hit_x_ff;
   logic signed [31:0]            d3_hit_y_ff;
   logic                          d3_inside_ff;
   logic [1:0]                    d3_block_ff;
   logic [1:0]                    d3_block_in;

   logic                          out_valid_ff;
   crt_pkg::rsp_type              out_ff;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign job_take = advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data = out_ff;

   for (genvar i = 0; i < STRIP_COUNT; i++) begin : g_bound
      logic signed [CMP_W-1:0] lft;
      assign lft = signed'(CMP_W'(cfg.strip_pitch) * CMP_W'(i))
                 - signed'(CMP_W'(cfg.grid_half_width));
      always_ff @(posedge clock) begin
         left_ff[i] <= lft <<< 14;
         right_ff[i] <= (lft + signed'(CMP_W'(cfg.strip_width))) <<< 14;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= signed'(CMP_W'(cfg.grid_half_width) << 14);
      r2_ff <= 62'(cfg.detector_radius) * 62'(cfg.detector_radius);
   end

   // lane l: plane l/2, axis l%2
   for (genvar l = 0; l < L; l++) begin : g_lane
      localparam int PL = l / 2;
      localparam int AX = l % 2;
      logic signed [31:0] h;
      logic [31:0]        hmag;
      assign h = (AX == 0) ? job.heading_x : job.heading_y;
      assign hmag = h[31] ? 32'(-h) : 32'(h);
      assign a_num_in[l] = 64'(job.dist_mag[PL]) * 64'(hmag);
      assign a_side_in.neg[l] = job.dist_neg[PL] ^ h[31] ^ job.heading_z[31];

      crt_div u_div (
         .clock (clock),
         .en    (advance),
         .num   (a_num_ff[l]),
         .den   (a_den_ff),
         .quo   (quo[l]),
         .ovf   (ovf[l])
      );

      always_comb begin
         logic [36:0]        qmag;
         logic signed [36:0] qs;
         logic signed [31:0] base;
         qmag = ovf[l] ? (37'(1) << 35) : 37'(quo[l]);
         if (qmag > (37'(1) << 34)) begin
            qmag = 37'(1) << 34;
         end
         qs = side_ff[DL-1].neg[l] ? -signed'(qmag) : signed'(qmag);
         base = (AX == 0) ? side_ff[DL-1].start_x : side_ff[DL-1].start_y;
         c_coord_in[l] = sat32(37'(base) + qs);
      end
   end

   assign a_side_in.zero_dir = job.zero_dir;
   assign a_side_in.start_x = job.start_x;
   assign a_side_in.start_y = job.start_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         for (int k = 0; k < DL; k++) begin
            dv_ff[k] <= 1'b0;
         end
         c_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= job_valid;
         dv_ff[0] <= a_valid_ff;
         for (int k = 1; k < DL; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         c_valid_ff <= dv_ff[DL-1];
         d1_valid_ff <= c_valid_ff;
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
         out_valid_ff <= d3_valid_ff;
      end
   end

   always_comb begin
      for (int g = 0; g < 2; g++) begin
         d3_block_in[g] = 1'b0;
         for (int i = 0; i < STRIP_COUNT; i++) begin
            if (d2_xr_ff[g] > left_ff[i] && d2_xr_ff[g] < right_ff[i]) begin
               d3_block_in[g] = 1'b1;
            end
         end
         if (!(d2_yr_ff[g] < half_ff && d2_yr_ff[g] > -half_ff)) begin
            d3_block_in[g] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0] ax;
      logic [31:0] ay;
      if (advance) begin
         for (int l = 0; l < L; l++) begin
            a_num_ff[l] <= a_num_in[l];
         end
         a_den_ff <= job.heading_z[31] ? 32'(-job.heading_z) : 32'(job.heading_z);
         a_side_ff <= a_side_in;

         side_ff[0] <= a_side_ff;
         for (int k = 1; k < DL; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         c_zero_ff <= side_ff[DL-1].zero_dir;
         for (int l = 0; l < L; l++) begin
            c_coord_ff[l] <= c_coord_in[l];
         end

         d1_zero_ff <= c_zero_ff;
         d1_hit_x_ff <= c_coord_ff[0];
         d1_hit_y_ff <= c_coord_ff[1];
         for (int g = 0; g < 2; g++) begin
            d1_xc_ff[g] <= 48'(c_coord_ff[2*g+2]) * 48'(cfg.rotation_cosine);
            d1_ys_ff[g] <= 48'(c_coord_ff[2*g+3]) * 48'(cfg.rotation_sine);
            d1_yc_ff[g] <= 48'(c_coord_ff[2*g+3]) * 48'(cfg.rotation_cosine);
            d1_xs_ff[g] <= 48'(c_coord_ff[2*g+2]) * 48'(cfg.rotation_sine);
         end
         ax = c_coord_ff[0][31] ? 32'(-c_coord_ff[0]) : 32'(c_coord_ff[0]);
         ay = c_coord_ff[1][31] ? 32'(-c_coord_ff[1]) : 32'(c_coord_ff[1]);
         d1_sqx_ff <= 64'(ax) * 64'(ax);
         d1_sqy_ff <= 64'(ay) * 64'(ay);

         d2_zero_ff <= d1_zero_ff;
         d2_hit_x_ff <= d1_hit_x_ff;
         d2_hit_y_ff <= d1_hit_y_ff;
         for (int g = 0; g < 2; g++) begin
            d2_xr_ff[g] <= CMP_W'(d1_xc_ff[g]) + CMP_W'(d1_ys_ff[g]);
            d2_yr_ff[g] <= CMP_W'(d1_yc_ff[g]) - CMP_W'(d1_xs_ff[g]);
         end
         d2_inside_ff <= ((d1_sqx_ff + d1_sqy_ff) < 64'(r2_ff));

         d3_zero_ff <= d2_zero_ff;
         d3_hit_x_ff <= d2_hit_x_ff;
         d3_hit_y_ff <= d2_hit_y_ff;
         d3_inside_ff <= d2_inside_ff;
         d3_block_ff <= d3_block_in;

         if (d3_zero_ff) begin
            out_ff.outcome <= crt_pkg::OUTCOME_ZERO_DIR;
            out_ff.hit_x <= 32'sd0;
            out_ff.hit_y <= 32'sd0;
         end else begin
            if (d3_block_ff[0]) begin
               out_ff.outcome <= crt_pkg::OUTCOME_FRONT_BLOCK;
            end else if (d3_block_ff[1]) begin
               out_ff.outcome <= crt_pkg::OUTCOME_REAR_BLOCK;
            end else if (d3_inside_ff) begin
               out_ff.outcome <= crt_pkg::OUTCOME_DETECTED;
            end else begin
               out_ff.outcome <= crt_pkg::OUTCOME_MISS;
            end
            out_ff.hit_x <= d3_hit_x_ff;
            out_ff.hit_y <= d3_hit_y_ff;
         end
      end
   end

endmodule

### design/collimator_ray_transmission_test.sv
// Top level of the collimator ray transmission test.
// Throughput: one ray per cycle while the output is not stalled, set by the
// 37-stage pipelined dividers, six in parallel.
// The back end stalls as a whole while its output register holds an untaken word.
// Reset: synchronous, active high; clears all valid bits and loads register defaults.
// Register words are accepted in every cycle.
module collimator_ray_transmission_test #(
   parameter int STRIP_COUNT = crt_pkg::STRIP_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   crt_req_if.sink    req_chan,
   crt_rsp_if.source  rsp_chan,
   crt_csr_if.sink    csr_chan
);

   crt_pkg::cfg_type cfg;
   crt_pkg::job_type front_job;
   logic             front_valid;
   logic             front_ready;
   crt_pkg::job_type back_job;
   logic             back_valid;
   logic             back_take;

   crt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .cfg       (cfg),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   crt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (front_job),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_job    (back_job),
      .pop_valid  (back_valid),
      .pop_take   (back_take)
   );

   crt_back #(
      .STRIP_COUNT (STRIP_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job       (back_job),
      .job_valid (back_valid),
      .job_take  (back_take),
      .rsp_chan  (rsp_chan)
   );

endmodule

### tb/sv/crt_checker.sv
// Checker: watches the channels, predicts each response word and compares it.
`timescale 1ns / 100ps
module crt_checker (
   input  logic clock,
   input  logic reset,
   crt_req_if   req,
   crt_rsp_if   rsp,
   crt_csr_if   csr,
   output int   failures,
   output int   pending
);

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam longint STEP_LIM = 64'sd1 << 34;

   crt_pkg::cfg_type   grid_cfg;
   crt_pkg::rsp_type   expected_hits[$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint plane_cross(longint p, longint pz, longint h, longint hz,
                                          longint plane);
      longint q;
      q = ((plane - pz) * h) / hz;
      q = clip(q, -STEP_LIM, STEP_LIM);
      return clip(p + q, SAT_LO, SAT_HI);
   endfunction

   function automatic bit strip_hit(crt_pkg::req_type r, longint plane);
      longint x, y, xr, yr, half, lft, rgt, cs, sn, hw;
      x = plane_cross(r.start_x, r.start_z, r.heading_x, r.heading_z, plane);
      y = plane_cross(r.start_y, r.start_z, r.heading_y, r.heading_z, plane);
      cs = grid_cfg.rotation_cosine;
      sn = grid_cfg.rotation_sine;
      hw = longint'(grid_cfg.grid_half_width);
      xr = x * cs + y * sn;
      yr = y * cs - x * sn;
      half = hw * 16384;
      if (!(yr < half && yr > -half)) return 1'b0;
      for (int i = 0; i < crt_pkg::STRIP_COUNT_DEF; i++) begin
         lft = longint'(i) * longint'(grid_cfg.strip_pitch) - hw;
         rgt = lft + longint'(grid_cfg.strip_width);
         if (xr > lft * 16384 && xr < rgt * 16384) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic crt_pkg::rsp_type trace_ray(crt_pkg::req_type r);
      crt_pkg::rsp_type o;
      longint hx, hy;
      longint unsigned ax, ay, rr;
      o = '0;
      if (r.heading_z == 0) begin
         o.outcome = crt_pkg::OUTCOME_ZERO_DIR;
         return o;
      end
      hx = plane_cross(r.start_x, r.start_z, r.heading_x, r.heading_z, 0);
      hy = plane_cross(r.start_y, r.start_z, r.heading_y, r.heading_z, 0);
      if (strip_hit(r, grid_cfg.front_grid_z)) o.outcome = crt_pkg::OUTCOME_FRONT_BLOCK;
      else if (strip_hit(r, grid_cfg.rear_grid_z)) o.outcome = crt_pkg::OUTCOME_REAR_BLOCK;
      else begin
         ax = hx < 0 ? -hx : hx;
         ay = hy < 0 ? -hy : hy;
         rr = grid_cfg.detector_radius;
         o.outcome = (ax * ax + ay * ay < rr * rr) ? crt_pkg::OUTCOME_DETECTED
                                                   : crt_pkg::OUTCOME_MISS;
      end
      o.hit_x = hx[31:0];
      o.hit_y = hy[31:0];
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      failures++;
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      crt_pkg::rsp_type want;
      if (reset) begin
         grid_cfg <= '{16'sd16384, 16'sd0, 32'sd6554, 32'sd10158080,
                       31'd294912, 31'd294912, 31'd29491, 31'd140083};
         expected_hits.delete();
      end else begin
         if (req.valid && req.ready) expected_hits.push_back(trace_ray(req.data));
         if (rsp.valid && rsp.ready) begin
            if (expected_hits.size() == 0)
               report("unexpected word", 32'(rsp.data.outcome), 32'd0);
            else begin
               want = expected_hits.pop_front();
               if (rsp.data.outcome !== want.outcome)
                  report("outcome", 32'(rsp.data.outcome), 32'(want.outcome));
               if (rsp.data.hit_x !== want.hit_x) report("hit_x", rsp.data.hit_x, want.hit_x);
               if (rsp.data.hit_y !== want.hit_y) report("hit_y", rsp.data.hit_y, want.hit_y);
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.data.index)
               crt_pkg::REG_COSINE:      grid_cfg.rotation_cosine <= csr.data.value[15:0];
               crt_pkg::REG_SINE:        grid_cfg.rotation_sine <= csr.data.value[15:0];
               crt_pkg::REG_FRONT_Z:     grid_cfg.front_grid_z <= csr.data.value;
               crt_pkg::REG_REAR_Z:      grid_cfg.rear_grid_z <= csr.data.value;
               crt_pkg::REG_RADIUS:      grid_cfg.detector_radius <= csr.data.value[30:0];
               crt_pkg::REG_HALF_WIDTH:  grid_cfg.grid_half_width <= csr.data.value[30:0];
               crt_pkg::REG_STRIP_WIDTH: grid_cfg.strip_width <= csr.data.value[30:0];
               crt_pkg::REG_STRIP_PITCH: grid_cfg.strip_pitch <= csr.data.value[30:0];
               default: ;
            endcase
         end
      end
      pending <= expected_hits.size();
   end
endmodule

### tb/sv/tb_top.sv
// Testbench top: clock, reset, ray and register stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;

   localparam int PHASES = 6;
   localparam int RAYS_PER_PHASE = 300;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   pending;
   int   idle_cycles = 0;
   bit   quiet = 1'b0;
   bit   hold_rsp = 1'b0;

   crt_req_if req_chan ();
   crt_rsp_if rsp_chan ();
   crt_csr_if csr_chan ();

   collimator_ray_transmission_test u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   crt_checker u_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan), .csr(csr_chan),
      .failures(failures), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side stalls
   initial begin
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_ray(crt_pkg::req_type r);
      req_chan.data <= r;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // valid stays high across back-to-back writes; the caller drops it
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_chan.data <= '{idx, val};
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] spread(int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic crt_pkg::req_type straight_ray(int x_mm10, int y_mm10,
                                                     logic signed [31:0] hz);
      crt_pkg::req_type r;
      r.start_x = (x_mm10 * 65536) / 10;
      r.start_y = (y_mm10 * 65536) / 10;
      r.start_z = 200 << 16;
      r.heading_x = 0;
      r.heading_y = 0;
      r.heading_z = hz;
      return r;
   endfunction

   function automatic crt_pkg::req_type random_ray();
      crt_pkg::req_type r;
      if ($urandom_range(0, 99) < 15) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(0, 3) == 0) r.heading_z = 0;
      end else begin
         r.start_x = spread(6 << 16);
         r.start_y = spread(6 << 16);
         r.start_z = $urandom_range(1, 300) << 16;
         r.heading_x = spread(1 << 26);
         r.heading_y = spread(1 << 26);
         r.heading_z = -$urandom_range(1 << 26, 1 << 30);
         if ($urandom_range(0, 9) == 0) begin
            r.start_z = -r.start_z;
            r.heading_z = -r.heading_z;
         end
      end
      return r;
   endfunction

   task automatic load_grid(int phase);
      logic [31:0] v [8];
      v = '{16384, 0, 6554, 10158080, 294912, 294912, 29491, 140083};
      case (phase)
         1: begin v[0] = 11585; v[1] = 11585; end
         2: v = '{-16384, 16384, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 0, 0};
         3: v = '{16384, -16384, 0, 5 << 16, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff};
         4: begin
            v[0] = spread(16384);
            v[1] = spread(16384);
            v[2] = $urandom_range(0, 300 << 16);
            v[3] = $urandom_range(0, 300 << 16);
            v[4] = $urandom_range(0, 10 << 16);
            v[5] = $urandom_range(0, 8 << 16);
            v[6] = $urandom_range(0, 3 << 16);
            v[7] = $urandom_range(0, 3 << 16);
         end
         default: ;
      endcase
      write_reg(crt_pkg::REG_COSINE, v[0]);
      write_reg(crt_pkg::REG_SINE, v[1]);
      write_reg(crt_pkg::REG_FRONT_Z, v[2]);
      write_reg(crt_pkg::REG_REAR_Z, v[3]);
      write_reg(crt_pkg::REG_RADIUS, v[4]);
      write_reg(crt_pkg::REG_HALF_WIDTH, v[5]);
      write_reg(crt_pkg::REG_STRIP_WIDTH, v[6]);
      write_reg(crt_pkg::REG_STRIP_PITCH, v[7]);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      crt_pkg::req_type r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays under reset geometry
      send_ray('0);
      send_ray({6{32'h7fff_ffff}});
      send_ray({6{32'h8000_0000}});
      r = {6{32'h8000_0000}}; r.heading_z = 0; send_ray(r);
      r = {6{32'h7fff_ffff}}; r.heading_z = 1; send_ray(r);
      r = {6{32'h8000_0000}}; r.heading_z = -1; send_ray(r);
      send_ray(straight_ray(-43, 0, -(1 << 30)));
      send_ray(straight_ray(0, 0, -(1 << 30)));
      send_ray(straight_ray(10, 0, -(1 << 30)));
      send_ray(straight_ray(10, 10, 1 << 30));
      send_ray(straight_ray(60, 0, -(1 << 30)));
      send_ray(straight_ray(10, 46, -(1 << 30)));
      send_ray(straight_ray(-45, 0, -(1 << 30)));
      send_ray(straight_ray(0, 45, -(1 << 30)));
      r = straight_ray(10, 0, -(1 << 30)); r.heading_x = 1 << 27; send_ray(r);
      r = straight_ray(10, 0, -(1 << 30)); r.heading_x = -(1 << 26); send_ray(r);
      r = straight_ray(0, 0, -(1 << 30)); r.start_x = 32'h7fff_ffff; send_ray(r);
      r = straight_ray(0, 0, 1); r.heading_x = 32'h7fff_ffff; send_ray(r);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         load_grid(p);
         for (int n = 0; n < RAYS_PER_PHASE; n++) begin
            if (p == 1 && n == 100) hold_rsp = 1'b1;
            if (p == PHASES - 1 && n == RAYS_PER_PHASE - 150) quiet = 1'b1;
            send_ray(random_ray());
         end
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

### collimator_ray_transmission_test.f
design/crt_pkg.sv
design/crt_ifs.sv
design/crt_front.sv
design/crt_queue.sv
design/crt_div.sv
design/crt_back.sv
design/collimator_ray_transmission_test.sv
tb/sv/crt_checker.sv
tb/sv/tb_top.sv
